// ----- sv/fss_pkg.sv -----
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types and score constants for the fuzzy subsequence scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

  // score field width and output tdata width (score padded to whole bytes)
  localparam int unsigned SCORE_W  = 13;
  localparam int unsigned OUT_TDATA_W = 16;

  // score points
  localparam logic [SCORE_W-1:0] SCORE_EMPTY  = 13'd100;
  localparam logic [SCORE_W-1:0] SCORE_EXACT  = 13'd1000;
  localparam logic [SCORE_W-1:0] SCORE_PREFIX = 13'd500;
  localparam logic [SCORE_W-1:0] MATCH_PTS    = 13'd10;
  localparam logic [SCORE_W-1:0] RUN_STEP     = 13'd10;
  localparam logic [SCORE_W-1:0] ALIGN_PTS    = 13'd5;
  localparam logic [SCORE_W-1:0] SUBSTR_PTS   = 13'd50;
  localparam logic [SCORE_W-1:0] SCORE_MAX    = 13'd8191;

  // input item kinds carried on tuser
  typedef enum logic [1:0] {
    MODE_NEEDLE       = 2'd0,
    MODE_NAME         = 2'd1,
    MODE_EMPTY_NEEDLE = 2'd2,
    MODE_EMPTY_NAME   = 2'd3
  } mode_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_SUB_INIT,
    OP_PFX_ADV,
    OP_SUB_ADV,
    OP_CON_ADV,
    OP_CON_SHIFT,
    OP_RES_EMPTY,
    OP_RES_PREFIX,
    OP_RES_NOMATCH,
    OP_RES_SCORE,
    OP_RES_HIT,
    OP_EMIT
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic scores_item;
    logic needle_empty;
    logic fits;
    logic eq;
    logic qi_last;
    logic sub_end;
    logic con_more;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/fss_ctrl.sv -----
// ----------------------------------------------------------------------------
// fss_ctrl
// Sequencer: loads characters, then walks the prefix check, the greedy
// subsequence walk and the substring search, and hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_tvalid_i,
  output logic                  s_tready_o,
  input  wire fss_pkg::status_t status_i,
  output fss_pkg::cmd_t         cmd_o
);
  import fss_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_EVAL    = 9'b000000010,
    ST_PFX_RD  = 9'b000000100,
    ST_PFX_CMP = 9'b000001000,
    ST_SUB_RD  = 9'b000010000,
    ST_SUB_CMP = 9'b000100000,
    ST_CON_RD  = 9'b001000000,
    ST_CON_CMP = 9'b010000000,
    ST_FIN     = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  // next state and operation
  always_comb begin
    state_d    = state_q;
    cmd_o.load = accept;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (accept && status_i.scores_item) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.needle_empty) begin
          cmd_o.op = OP_RES_EMPTY;
          state_d  = ST_FIN;
        end else begin
          cmd_o.op = OP_INIT;
          state_d  = status_i.fits ? ST_PFX_RD : ST_SUB_RD;
        end
      end
      ST_PFX_RD: state_d = ST_PFX_CMP;
      ST_PFX_CMP: begin
        if (!status_i.eq) begin
          cmd_o.op = OP_SUB_INIT;
          state_d  = ST_SUB_RD;
        end else if (status_i.qi_last) begin
          cmd_o.op = OP_RES_PREFIX;
          state_d  = ST_FIN;
        end else begin
          cmd_o.op = OP_PFX_ADV;
          state_d  = ST_PFX_RD;
        end
      end
      ST_SUB_RD: begin
        if (status_i.sub_end) begin
          cmd_o.op = OP_RES_NOMATCH;
          state_d  = ST_FIN;
        end else begin
          state_d = ST_SUB_CMP;
        end
      end
      ST_SUB_CMP: begin
        cmd_o.op = OP_SUB_ADV;
        state_d  = (status_i.eq && status_i.qi_last) ? ST_CON_RD : ST_SUB_RD;
      end
      ST_CON_RD: state_d = ST_CON_CMP;
      ST_CON_CMP: begin
        if (status_i.eq) begin
          if (status_i.qi_last) begin
            cmd_o.op = OP_RES_HIT;
            state_d  = ST_FIN;
          end else begin
            cmd_o.op = OP_CON_ADV;
            state_d  = ST_CON_RD;
          end
        end else if (status_i.con_more) begin
          cmd_o.op = OP_CON_SHIFT;
          state_d  = ST_CON_RD;
        end else begin
          cmd_o.op = OP_RES_SCORE;
          state_d  = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_score_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_i.scores_item) |=> (state_q == ST_EVAL))
    else $error("scoring did not start after a scoring transfer");
  a_fin_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !status_i.out_busy) |=> (state_q == ST_IDLE))
    else $error("result hand-off did not return to idle");
`endif

endmodule

`default_nettype wire

// ----- sv/fss_dp.sv -----
// ----------------------------------------------------------------------------
// fss_dp
// Datapath: needle and name stores, walk counters, score accumulator and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_dp #(
  parameter int unsigned MAX_NAME_LEN   = 32,
  parameter int unsigned MAX_NEEDLE_LEN = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       s_tdata_i,
  input  wire logic [1:0]       s_tuser_i,
  input  wire logic             s_tlast_i,
  input  wire fss_pkg::cmd_t    cmd_i,
  output fss_pkg::status_t      status_o,
  input  wire logic             m_tready_i,
  output logic                  m_tvalid_o,
  output logic [fss_pkg::OUT_TDATA_W-1:0] m_tdata_o,
  output logic [1:0]            m_tuser_o
);
  import fss_pkg::*;

  localparam int unsigned NLW = $clog2(MAX_NEEDLE_LEN + 1);
  localparam int unsigned MLW = $clog2(MAX_NAME_LEN + 1);
  localparam int unsigned NIW = (MAX_NEEDLE_LEN > 1) ? $clog2(MAX_NEEDLE_LEN) : 1;
  localparam int unsigned MIW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int unsigned CW  = ((NLW > MLW) ? NLW : MLW) + 2;

  // character stores
  logic [7:0] needle_mem [MAX_NEEDLE_LEN];
  logic [7:0] name_mem   [MAX_NAME_LEN];
  logic [7:0] needle_rd_q, name_rd_q;

  // control state
  logic [NLW-1:0] nl_q, nl_d;
  logic [MLW-1:0] ml_q, ml_d;
  logic           closed_q, closed_d;
  logic           nov_q, nov_d;
  logic           trunc_q, trunc_d;
  logic [NLW-1:0] qi_q, qi_d;
  logic [MLW-1:0] ni_q, ni_d;
  logic [MLW-1:0] s_q, s_d;
  logic           have_last_q, have_last_d;
  logic           out_valid_q, out_valid_d;

  // score payload
  logic [SCORE_W-1:0] sc_q, sc_d;
  logic [SCORE_W-1:0] run_q, run_d;
  logic [MLW-1:0]     last_pos_q, last_pos_d;
  logic               res_m_q, res_m_d;
  logic [SCORE_W-1:0] res_sc_q, res_sc_d;
  logic               out_m_q, out_sc_unused;
  logic [SCORE_W-1:0] out_sc_q;
  logic               out_ov_q;

  logic           nwe, mwe;
  logic [NIW-1:0] nwa;
  logic [MIW-1:0] mwa;
  mode_e          mode;

  logic               adj, align;
  logic [MLW:0]       next_pos;
  logic [SCORE_W-1:0] run_new;
  logic [SCORE_W:0]   walk_sum, hit_sum;
  logic [SCORE_W-1:0] walk_sat, hit_sat;

  assign mode = mode_e'(s_tuser_i);
  assign out_sc_unused = 1'b0;

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (nwe) needle_mem[nwa] <= s_tdata_i;
    needle_rd_q <= needle_mem[qi_q[NIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (mwe) name_mem[mwa] <= s_tdata_i;
    name_rd_q <= name_mem[ni_q[MIW-1:0]];
  end

  // status toward the controller
  always_comb begin
    status_o.scores_item  = (mode == MODE_NAME && s_tlast_i) || (mode == MODE_EMPTY_NAME);
    status_o.needle_empty = (nl_q == '0);
    status_o.fits         = CW'(nl_q) <= CW'(ml_q);
    status_o.eq           = (needle_rd_q == name_rd_q);
    status_o.qi_last      = (CW'(qi_q) + CW'(1)) == CW'(nl_q);
    status_o.sub_end      = CW'(ni_q) == CW'(ml_q);
    status_o.con_more     = (CW'(s_q) + CW'(1) + CW'(nl_q)) <= CW'(ml_q);
    status_o.out_busy     = out_valid_q && !m_tready_i;
  end

  // walk scoring terms
  always_comb begin
    next_pos = {1'b0, last_pos_q} + (MLW+1)'(1);
    adj      = have_last_q ? ({1'b0, ni_q} == next_pos) : (ni_q == '0);
    align    = CW'(ni_q) == CW'(qi_q);
    run_new  = adj ? (run_q + RUN_STEP) : '0;
    walk_sum = {1'b0, sc_q} + {1'b0, MATCH_PTS}
             + (adj ? {1'b0, run_new} : '0)
             + (align ? {1'b0, ALIGN_PTS} : '0);
    walk_sat = (walk_sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : walk_sum[SCORE_W-1:0];
    hit_sum  = {1'b0, sc_q} + {1'b0, SUBSTR_PTS};
    hit_sat  = (hit_sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : hit_sum[SCORE_W-1:0];
  end

  // next-state logic
  always_comb begin
    nl_d        = nl_q;
    ml_d        = ml_q;
    closed_d    = closed_q;
    nov_d       = nov_q;
    trunc_d     = trunc_q;
    qi_d        = qi_q;
    ni_d        = ni_q;
    s_d         = s_q;
    have_last_d = have_last_q;
    sc_d        = sc_q;
    run_d       = run_q;
    last_pos_d  = last_pos_q;
    res_m_d     = res_m_q;
    res_sc_d    = res_sc_q;
    out_valid_d = out_valid_q && !m_tready_i;
    nwe         = 1'b0;
    nwa         = nl_q[NIW-1:0];
    mwe         = 1'b0;
    mwa         = ml_q[MIW-1:0];

    // character loading
    if (cmd_i.load) begin
      case (mode)
        MODE_NEEDLE: begin
          if (closed_q) begin
            nwe      = 1'b1;
            nwa      = '0;
            nl_d     = NLW'(1);
            nov_d    = 1'b0;
            closed_d = 1'b0;
          end else if (nl_q < NLW'(MAX_NEEDLE_LEN)) begin
            nwe  = 1'b1;
            nl_d = nl_q + NLW'(1);
          end else begin
            nov_d = 1'b1;
          end
          if (s_tlast_i) closed_d = 1'b1;
        end
        MODE_NAME: begin
          closed_d = 1'b1;
          if (ml_q < MLW'(MAX_NAME_LEN)) begin
            mwe  = 1'b1;
            ml_d = ml_q + MLW'(1);
          end else begin
            trunc_d = 1'b1;
          end
        end
        MODE_EMPTY_NEEDLE: begin
          nl_d     = '0;
          closed_d = 1'b1;
          nov_d    = 1'b0;
        end
        MODE_EMPTY_NAME: begin
          closed_d = 1'b1;
          ml_d     = '0;
          trunc_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // scoring operations
    case (cmd_i.op)
      OP_INIT: begin
        qi_d        = '0;
        ni_d        = '0;
        s_d         = '0;
        sc_d        = '0;
        run_d       = '0;
        have_last_d = 1'b0;
      end
      OP_SUB_INIT: begin
        qi_d = '0;
        ni_d = '0;
      end
      OP_PFX_ADV, OP_CON_ADV: begin
        qi_d = qi_q + NLW'(1);
        ni_d = ni_q + MLW'(1);
      end
      OP_SUB_ADV: begin
        if (status_o.eq) begin
          sc_d        = walk_sat;
          run_d       = run_new;
          have_last_d = 1'b1;
          last_pos_d  = ni_q;
          if (status_o.qi_last) begin
            qi_d = '0;
            ni_d = '0;
            s_d  = '0;
          end else begin
            qi_d = qi_q + NLW'(1);
            ni_d = ni_q + MLW'(1);
          end
        end else begin
          ni_d = ni_q + MLW'(1);
        end
      end
      OP_CON_SHIFT: begin
        s_d  = s_q + MLW'(1);
        qi_d = '0;
        ni_d = s_q + MLW'(1);
      end
      OP_RES_EMPTY: begin
        res_m_d  = 1'b1;
        res_sc_d = SCORE_EMPTY;
      end
      OP_RES_PREFIX: begin
        res_m_d  = 1'b1;
        res_sc_d = (CW'(nl_q) == CW'(ml_q)) ? SCORE_EXACT : SCORE_PREFIX;
      end
      OP_RES_NOMATCH: begin
        res_m_d  = 1'b0;
        res_sc_d = '0;
      end
      OP_RES_SCORE: begin
        res_m_d  = 1'b1;
        res_sc_d = sc_q;
      end
      OP_RES_HIT: begin
        res_m_d  = 1'b1;
        res_sc_d = hit_sat;
      end
      OP_EMIT: begin
        out_valid_d = 1'b1;
        ml_d        = '0;
        trunc_d     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_q        <= '0;
      ml_q        <= '0;
      closed_q    <= 1'b1;
      nov_q       <= 1'b0;
      trunc_q     <= 1'b0;
      qi_q        <= '0;
      ni_q        <= '0;
      s_q         <= '0;
      have_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      nl_q        <= nl_d;
      ml_q        <= ml_d;
      closed_q    <= closed_d;
      nov_q       <= nov_d;
      trunc_q     <= trunc_d;
      qi_q        <= qi_d;
      ni_q        <= ni_d;
      s_q         <= s_d;
      have_last_q <= have_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // score and result payload
  always_ff @(posedge clk_i) begin
    sc_q       <= sc_d;
    run_q      <= run_d;
    last_pos_q <= last_pos_d;
    res_m_q    <= res_m_d;
    res_sc_q   <= res_sc_d;
    if (cmd_i.op == OP_EMIT) begin
      out_m_q  <= res_m_q;
      out_sc_q <= res_sc_q;
      out_ov_q <= nov_q || trunc_q;
    end
  end

  // output transfer
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(OUT_TDATA_W-SCORE_W){out_sc_unused}}, out_sc_q};
  assign m_tuser_o  = {out_ov_q, out_m_q};

`ifndef SYNTHESIS
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_m_q) |-> (out_sc_q == '0))
    else $error("no-match result carries a nonzero score");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(nl_q) <= CW'(MAX_NEEDLE_LEN)) && (CW'(ml_q) <= CW'(MAX_NAME_LEN)))
    else $error("stored length beyond store size");
`endif

endmodule

`default_nettype wire

// ----- sv/fuzzy_subsequence_scorer_unit.sv -----
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer_unit
// Scores candidate names against a stored needle string.
// ----------------------------------------------------------------------------
// After the final character of a name (or an empty-name transfer) the unit
// stops taking input and scores the name from its character stores; every
// compare passes through a read state, which reads both stores (registered
// read), and a compare state. A score runs through setup, the prefix check
// (when the needle fits), the greedy subsequence walk and the substring
// search, then the hand-off; an empty needle skips the checks and short
// misses end early. The hand-off waits while the previous result is still
// unaccepted. The result sits in an output register, so characters of the
// next name are taken while it waits.
// Output tuser bit 0 is matched, bit 1 is overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_subsequence_scorer_unit #(
  parameter int unsigned MAX_NAME_LEN   = 32,
  parameter int unsigned MAX_NEEDLE_LEN = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [7:0]  s_tdata_i,   // [7:0] char_code
  input  wire logic [1:0]  s_tuser_i,   // [1:0] mode
  input  wire logic        s_tlast_i,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [15:0]      m_tdata_o,   // [12:0] score, [15:13] zero
  output logic [1:0]       m_tuser_o    // [0] matched, [1] overflow
);
  import fss_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  fss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // stores and score datapath
  fss_dp #(
    .MAX_NAME_LEN   (MAX_NAME_LEN),
    .MAX_NEEDLE_LEN (MAX_NEEDLE_LEN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tlast_i  (s_tlast_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tready_i (m_tready_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule

`default_nettype wire

// ----- verif/fuzzy_subsequence_scorer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer_unit_tb
// Self-checking bench for the fuzzy subsequence scorer: drives needle and
// name characters over the input stream, predicts each score in a small
// scoreboard and compares every output transfer field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_subsequence_scorer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fss_pkg::*;

  localparam int NEEDLE_DEPTH = 32;
  localparam int NAME_DEPTH   = 32;
  localparam int N_ITEMS      = 1600;
  localparam int QUIET_FROM   = 1350;
  localparam int DRAIN_CYCLES = 2200;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 400;

  // one predicted output transfer
  typedef struct packed {
    logic               matched;
    logic [SCORE_W-1:0] score;
    logic               overflow;
  } score_item_t;

  // scoreboard: private copy of needle and name stores plus predicted scores
  class score_checker;
    byte unsigned needle_b[NEEDLE_DEPTH];
    byte unsigned name_b[NAME_DEPTH];
    int           needle_len;
    int           name_len;
    bit           needle_closed;
    bit           needle_cut;
    bit           name_cut;
    score_item_t  due_scores[$];
    int           n_errors;

    function new();
      needle_len    = 0;
      name_len      = 0;
      needle_closed = 1'b1;
      needle_cut    = 1'b0;
      name_cut      = 1'b0;
      n_errors      = 0;
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      n_errors++;
    endfunction

    // needle found as a contiguous run inside the name
    function bit has_substring();
      int  s;
      int  k;
      bit  hit;
      if (needle_len > name_len) return 1'b0;
      for (s = 0; s + needle_len <= name_len; s++) begin
        hit = 1'b1;
        for (k = 0; k < needle_len; k++)
          if (name_b[s+k] != needle_b[k]) hit = 1'b0;
        if (hit) return 1'b1;
      end
      return 1'b0;
    endfunction

    // score of the stored name against the stored needle
    function bit rate_name(output int pts);
      int qi;
      int ni;
      int k;
      int run;
      int last_pos;
      bit have_last;
      bit found;
      bit pfx;
      pts       = 0;
      run       = 0;
      last_pos  = 0;
      have_last = 1'b0;
      if (needle_len == 0) begin
        pts = SCORE_EMPTY;
        return 1'b1;
      end
      // prefix and exact match
      if (needle_len <= name_len) begin
        pfx = 1'b1;
        for (k = 0; k < needle_len; k++)
          if (name_b[k] != needle_b[k]) pfx = 1'b0;
        if (pfx) begin
          pts = (needle_len == name_len) ? SCORE_EXACT : SCORE_PREFIX;
          return 1'b1;
        end
      end
      // greedy walk, every needle character must be found
      ni = 0;
      for (qi = 0; qi < needle_len; qi++) begin
        found = 1'b0;
        while (ni < name_len && !found) begin
          if (name_b[ni] == needle_b[qi]) begin
            pts += MATCH_PTS;
            if ((!have_last && ni == 0) || (have_last && ni == last_pos + 1)) begin
              run += RUN_STEP;
              pts += run;
            end else begin
              run = 0;
            end
            if (ni == qi) pts += ALIGN_PTS;
            have_last = 1'b1;
            last_pos  = ni;
            found     = 1'b1;
          end
          ni++;
        end
        if (!found) begin
          pts = 0;
          return 1'b0;
        end
      end
      if (has_substring()) pts += SUBSTR_PTS;
      return 1'b1;
    endfunction

    function void push_score();
      score_item_t e;
      int          pts;
      bit          hit;
      hit        = rate_name(pts);
      e.matched  = hit;
      e.score    = !hit ? '0 : (pts > SCORE_MAX) ? SCORE_MAX : SCORE_W'(pts);
      e.overflow = needle_cut | name_cut;
      due_scores.push_back(e);
      name_len = 0;
      name_cut = 1'b0;
    endfunction

    // accepted input transfer
    function void note_transfer(mode_e md, logic [7:0] ch, logic lst);
      case (md)
        MODE_NEEDLE: begin
          if (needle_closed) begin
            needle_len    = 0;
            needle_cut    = 1'b0;
            needle_closed = 1'b0;
          end
          if (needle_len < NEEDLE_DEPTH) begin
            needle_b[needle_len] = ch;
            needle_len           = needle_len + 1;
          end else begin
            needle_cut = 1'b1;
          end
          if (lst) needle_closed = 1'b1;
        end
        MODE_NAME: begin
          needle_closed = 1'b1;
          if (name_len < NAME_DEPTH) begin
            name_b[name_len] = ch;
            name_len         = name_len + 1;
          end else begin
            name_cut = 1'b1;
          end
          if (lst) push_score();
        end
        MODE_EMPTY_NEEDLE: begin
          needle_len    = 0;
          needle_closed = 1'b1;
          needle_cut    = 1'b0;
        end
        default: begin
          needle_closed = 1'b1;
          name_len      = 0;
          name_cut      = 1'b0;
          push_score();
        end
      endcase
    endfunction

    // accepted output transfer
    function void check_score(score_item_t got);
      score_item_t e;
      if (due_scores.size() == 0) begin
        report($sformatf("result with nothing pending (score %0d)", got.score));
        return;
      end
      e = due_scores.pop_front();
      if (got.matched !== e.matched)
        report($sformatf("matched got %b want %b", got.matched, e.matched));
      if (got.score !== e.score)
        report($sformatf("score got %0d want %0d", got.score, e.score));
      if (got.overflow !== e.overflow)
        report($sformatf("overflow got %b want %b", got.overflow, e.overflow));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  score_checker sb;
  int           n_sent;
  int           cycle_cnt;
  bit           idle_en;
  bit           hold_req;
  logic [7:0]   needle_q[$];

  fuzzy_subsequence_scorer_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),    // [7:0] char_code
    .s_tuser_i  (s_tuser),    // [1:0] mode
    .s_tlast_i  (s_tlast),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),    // [12:0] score, [15:13] zero
    .m_tuser_o  (m_tuser)     // [0] matched, [1] overflow
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    score_item_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got.matched  = m_tuser[0];
      got.overflow = m_tuser[1];
      got.score    = m_tdata[SCORE_W-1:0];
      sb.check_score(got);
    end
  end

  // receiver: random stall bursts and one long hold-off
  initial begin
    int n;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        m_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // mostly a small alphabet so that names hit the needle, sometimes any byte
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return 8'("a") + 8'($urandom_range(0, 4));
  endfunction

  // one input transfer, with an optional gap in front
  task automatic send_item(mode_e md, logic [7:0] ch, logic lst);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= md;
    s_tlast  <= lst;
    do @(posedge clk_i); while (!s_tready);
    sb.note_transfer(md, ch, lst);
    n_sent++;
  endtask

  task automatic send_text(mode_e md, logic [7:0] txt[$], bit close);
    int i;
    for (i = 0; i < txt.size(); i++)
      send_item(md, txt[i], close && (i == txt.size() - 1));
  endtask

  // sender stays quiet until every predicted score has come back
  task automatic drain_scores();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.due_scores.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_needle(int len, bit close);
    int i;
    needle_q.delete();
    for (i = 0; i < len; i++) needle_q.push_back(pick_char());
    send_text(MODE_NEEDLE, needle_q, close);
  endtask

  // name built around the current needle in one of several shapes
  task automatic send_name(bit go_long);
    logic [7:0] nm[$];
    int         kind;
    kind = go_long ? 6 : $urandom_range(0, 9);
    case (kind)
      0: nm = needle_q;
      1: begin
        nm = needle_q;
        repeat ($urandom_range(1, 4)) nm.push_back(pick_char());
      end
      2, 3, 4: begin
        foreach (needle_q[i]) begin
          if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) nm.push_back(pick_char());
          if ($urandom_range(0, 9) != 0) nm.push_back(needle_q[i]);
        end
        repeat ($urandom_range(0, 2)) nm.push_back(pick_char());
      end
      5: begin
        repeat ($urandom_range(1, 3)) nm.push_back(pick_char());
        foreach (needle_q[i]) nm.push_back(needle_q[i]);
        repeat ($urandom_range(0, 2)) nm.push_back(pick_char());
      end
      6: repeat ($urandom_range(30, 34)) nm.push_back(pick_char());
      default: repeat ($urandom_range(1, 8)) nm.push_back(pick_char());
    endcase
    if (nm.size() == 0)
      send_item(MODE_EMPTY_NAME, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    else
      send_text(MODE_NAME, nm, 1'b1);
  endtask

  // main sequence
  initial begin
    int g;
    int r;
    int len;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= MODE_NEEDLE;
    s_tlast  <= 1'b0;
    rst_ni    = 1'b0;
    cycle_cnt = 0;
    n_sent    = 0;
    idle_en   = 1'b1;
    hold_req  = 1'b0;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty needle after reset
    send_item(MODE_EMPTY_NAME, 8'hFF, 1'b1);
    send_item(MODE_NAME, "x", 1'b1);
    // exact, prefix, substring, scattered and missing
    send_text(MODE_NEEDLE, '{"a", "b"}, 1'b1);
    send_text(MODE_NAME, '{"a", "b"}, 1'b1);
    send_text(MODE_NAME, '{"a", "b", "z"}, 1'b1);
    send_text(MODE_NAME, '{"z", "a", "b"}, 1'b1);
    send_text(MODE_NAME, '{"a", "z", "b"}, 1'b1);
    send_item(MODE_NAME, "b", 1'b1);
    send_item(MODE_EMPTY_NAME, 8'h00, 1'b0);
    // open needle closed by the first name character, byte extremes
    send_item(MODE_NEEDLE, 8'h00, 1'b0);
    send_text(MODE_NAME, '{8'h00, 8'hFF}, 1'b1);
    // empty-needle command, then an empty name
    send_item(MODE_EMPTY_NEEDLE, 8'hFF, 1'b0);
    send_item(MODE_EMPTY_NAME, 8'h00, 1'b0);
    needle_q.delete();
    drain_scores();

    // random groups of well-formed needles and names with some noise
    g = 0;
    while (n_sent < N_ITEMS) begin
      if (n_sent >= QUIET_FROM) idle_en = 1'b0;
      if (g == 40) hold_req = 1'b1;
      if (g == 120) drain_scores();
      r = $urandom_range(0, 99);
      if (g == 0) begin
        send_needle(34, 1'b1);
      end else if (g == 1) begin
        send_name(1'b1);
      end else if (r < 12) begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 5);
        send_needle(len, $urandom_range(0, 6) != 0);
      end else if (r < 16) begin
        needle_q.delete();
        send_item(MODE_EMPTY_NEEDLE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (r < 22) begin
        send_item(MODE_EMPTY_NAME, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (r < 26) begin
        // name dropped halfway, sometimes after its store filled up
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
        repeat (len) send_item(MODE_NAME, pick_char(), 1'b0);
        send_item(MODE_EMPTY_NAME, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_name($urandom_range(0, 39) == 0);
      end
      g++;
    end
    s_tvalid <= 1'b0;

    // wait for the last scores, then a quiet tail
    while (sb.due_scores.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
